>>> hdl/frr_pkg.sv
// Shared types and constants of the fragmented response reassembler.
`default_nettype none
package frr_pkg;

    localparam int MAX_PAYLOAD_DEF = 255;
    localparam int RESP_DEPTH_DEF  = 4096;

    localparam logic [12:0] LIMIT_RST   = 13'd4096;
    localparam logic [31:0] OVERALL_RST = 32'd30000;
    localparam logic [15:0] IDLE_RST    = 16'd2000;
    localparam logic [7:0]  RESP_RST    = 8'd4;
    localparam logic [7:0]  NACK_RST    = 8'd3;

    typedef enum logic [1:0] {
        ACT_START = 2'd0,
        ACT_BYTE  = 2'd1,
        ACT_TICK  = 2'd2,
        ACT_READ  = 2'd3
    } t_action;

    typedef enum logic [2:0] {
        PH_IDLE    = 3'd0,
        PH_RECV    = 3'd1,
        PH_DONE    = 3'd2,
        PH_NACK    = 3'd3,
        PH_TIMEOUT = 3'd4
    } t_phase;

    typedef enum logic [2:0] {
        REG_LIMIT   = 3'd0,
        REG_OVERALL = 3'd1,
        REG_IDLE    = 3'd2,
        REG_RESP    = 3'd3,
        REG_NACK    = 3'd4
    } t_reg_index;

    typedef enum logic [3:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_EXEC,
        ST_DECODE,
        ST_CHECK,
        ST_COPY_RD,
        ST_COPY_WR,
        ST_OUT
    } t_state;

    typedef struct packed {
        logic latch;
        logic exec;
        logic decode;
        logic check;
        logic copy_rd;
        logic copy_wr;
        logic clear_step;
        logic out_load;
    } t_cmd;

    typedef struct packed {
        t_action action;
        logic    frame_end;
        logic    frag_go;
        logic    copy_go;
        logic    copy_last;
        logic    clear_last;
    } t_status;

endpackage
`default_nettype wire

>>> hdl/fragmented_response_reassembler_unit.sv
// Top level of the fragmented response reassembler.
//
//  channel  direction  handshake               payload
//  in       to block   i_in_valid / o_in_stall   action, data_byte, frame_end, seq, read_address
//  out      from block o_out_valid / i_out_stall send_ack .. read_byte
//  cfg      to block   i_cfg_valid / o_cfg_ready i_cfg_index, i_cfg_data
//
// Frame byte, tick and read items pass through the latch, execute and output steps; a
// last frame byte adds a decode step, a check step for a matching fragment, plus a read
// and a write step per payload byte copied from the frame store.
// A start item also runs a clearing pass over every entry of the response store; the
// same pass runs after reset, and no item is taken during it.
// A result waits in the output register; a stalled output holds only the final step.
`default_nettype none
module fragmented_response_reassembler_unit #(
    parameter int MAX_PAYLOAD = frr_pkg::MAX_PAYLOAD_DEF,
    parameter int RESP_DEPTH  = frr_pkg::RESP_DEPTH_DEF
) (
    input  wire         i_clk,
    input  wire         i_rst_n,
    input  wire         i_cfg_valid,
    output logic        o_cfg_ready,
    input  wire  [2:0]  i_cfg_index,
    input  wire  [31:0] i_cfg_data,
    input  wire         i_in_valid,
    output logic        o_in_stall,
    input  wire  [1:0]  i_action,
    input  wire  [7:0]  i_data_byte,
    input  wire         i_frame_end,
    input  wire  [7:0]  i_seq,
    input  wire  [11:0] i_read_address,
    output logic        o_out_valid,
    input  wire         i_out_stall,
    output logic        o_send_ack,
    output logic [7:0]  o_ack_seq,
    output logic [2:0]  o_outcome,
    output logic [12:0] o_response_length,
    output logic [7:0]  o_fragments_received,
    output logic [7:0]  o_fragments_expected,
    output logic [7:0]  o_read_byte
);

    frr_pkg::t_cmd    w_cmd;
    frr_pkg::t_status w_status;

    assign o_cfg_ready = 1'b1;

    frr_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .i_status    (w_status),
        .o_cmd       (w_cmd)
    );

    frr_datapath #(
        .MAX_PAYLOAD (MAX_PAYLOAD),
        .RESP_DEPTH  (RESP_DEPTH)
    ) u_datapath (
        .i_clk                (i_clk),
        .i_rst_n              (i_rst_n),
        .i_cmd                (w_cmd),
        .o_status             (w_status),
        .i_cfg_valid          (i_cfg_valid),
        .i_cfg_index          (i_cfg_index),
        .i_cfg_data           (i_cfg_data),
        .i_action             (i_action),
        .i_data_byte          (i_data_byte),
        .i_frame_end          (i_frame_end),
        .i_seq                (i_seq),
        .i_read_address       (i_read_address),
        .o_send_ack           (o_send_ack),
        .o_ack_seq            (o_ack_seq),
        .o_outcome            (o_outcome),
        .o_response_length    (o_response_length),
        .o_fragments_received (o_fragments_received),
        .o_fragments_expected (o_fragments_expected),
        .o_read_byte          (o_read_byte)
    );

endmodule
`default_nettype wire

>>> hdl/frr_ctrl.sv
// Sequencing state machine and output valid of the reassembler.
`default_nettype none
module frr_ctrl (
    input  wire            i_clk,
    input  wire            i_rst_n,
    input  wire            i_in_valid,
    output logic           o_in_stall,
    output logic           o_out_valid,
    input  wire            i_out_stall,
    input  frr_pkg::t_status i_status,
    output frr_pkg::t_cmd  o_cmd
);

    frr_pkg::t_state r_state, n_state;
    logic r_out_valid, n_out_valid;
    logic r_clr_item, n_clr_item;

    // State and output valid registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= frr_pkg::ST_CLEAR;
            r_out_valid <= 1'b0;
            r_clr_item  <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
            r_clr_item  <= n_clr_item;
        end
    end

    // Next state and commands
    always_comb begin
        n_state     = r_state;
        o_cmd       = '0;
        n_out_valid = r_out_valid && i_out_stall;
        n_clr_item  = r_clr_item;
        case (r_state)
            frr_pkg::ST_CLEAR: begin
                o_cmd.clear_step = 1'b1;
                // a clear started by a start item still owes its result
                if (i_status.clear_last) begin
                    n_state    = r_clr_item ? frr_pkg::ST_OUT : frr_pkg::ST_IDLE;
                    n_clr_item = 1'b0;
                end
            end
            frr_pkg::ST_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.latch = 1'b1;
                    n_state     = frr_pkg::ST_EXEC;
                end
            end
            frr_pkg::ST_EXEC: begin
                o_cmd.exec = 1'b1;
                if (i_status.action == frr_pkg::ACT_START) begin
                    n_state    = frr_pkg::ST_CLEAR;
                    n_clr_item = 1'b1;
                end else if (i_status.action == frr_pkg::ACT_BYTE && i_status.frame_end) begin
                    n_state = frr_pkg::ST_DECODE;
                end else begin
                    n_state = frr_pkg::ST_OUT;
                end
            end
            frr_pkg::ST_DECODE: begin
                o_cmd.decode = 1'b1;
                n_state = i_status.frag_go ? frr_pkg::ST_CHECK : frr_pkg::ST_OUT;
            end
            frr_pkg::ST_CHECK: begin
                o_cmd.check = 1'b1;
                n_state = i_status.copy_go ? frr_pkg::ST_COPY_RD : frr_pkg::ST_OUT;
            end
            frr_pkg::ST_COPY_RD: begin
                o_cmd.copy_rd = 1'b1;
                n_state = frr_pkg::ST_COPY_WR;
            end
            frr_pkg::ST_COPY_WR: begin
                o_cmd.copy_wr = 1'b1;
                n_state = i_status.copy_last ? frr_pkg::ST_OUT : frr_pkg::ST_COPY_RD;
            end
            frr_pkg::ST_OUT: begin
                if (!r_out_valid || !i_out_stall) begin
                    o_cmd.out_load = 1'b1;
                    n_out_valid    = 1'b1;
                    n_state        = frr_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = frr_pkg::ST_IDLE;
            end
        endcase
    end

    assign o_in_stall  = (r_state != frr_pkg::ST_IDLE);
    assign o_out_valid = r_out_valid;

endmodule
`default_nettype wire

>>> hdl/frr_datapath.sv
// Frame and response stores, transaction registers and result register.
`default_nettype none
module frr_datapath #(
    parameter int MAX_PAYLOAD = frr_pkg::MAX_PAYLOAD_DEF,
    parameter int RESP_DEPTH  = frr_pkg::RESP_DEPTH_DEF
) (
    input  wire          i_clk,
    input  wire          i_rst_n,
    input  frr_pkg::t_cmd i_cmd,
    output frr_pkg::t_status o_status,
    input  wire          i_cfg_valid,
    input  wire  [2:0]   i_cfg_index,
    input  wire  [31:0]  i_cfg_data,
    input  wire  [1:0]   i_action,
    input  wire  [7:0]   i_data_byte,
    input  wire          i_frame_end,
    input  wire  [7:0]   i_seq,
    input  wire  [11:0]  i_read_address,
    output logic         o_send_ack,
    output logic [7:0]   o_ack_seq,
    output logic [2:0]   o_outcome,
    output logic [12:0]  o_response_length,
    output logic [7:0]   o_fragments_received,
    output logic [7:0]   o_fragments_expected,
    output logic [7:0]   o_read_byte
);

    localparam int AW        = $clog2(RESP_DEPTH);
    localparam int FW        = (MAX_PAYLOAD > 1) ? $clog2(MAX_PAYLOAD) : 1;
    localparam int FRAG_DATA = MAX_PAYLOAD - 2;
    localparam logic [8:0]  FRAME_MAX = 9'(MAX_PAYLOAD + 4);
    localparam logic [16:0] DEPTH17   = 17'(RESP_DEPTH);

    logic [7:0] r_frame_mem [MAX_PAYLOAD];
    logic [7:0] r_resp_mem  [RESP_DEPTH];

    // Configuration registers
    logic [12:0] r_limit;
    logic [31:0] r_ov_to;
    logic [15:0] r_id_to;
    logic [7:0]  r_resp_code, r_nack_code;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_limit     <= frr_pkg::LIMIT_RST;
            r_ov_to     <= frr_pkg::OVERALL_RST;
            r_id_to     <= frr_pkg::IDLE_RST;
            r_resp_code <= frr_pkg::RESP_RST;
            r_nack_code <= frr_pkg::NACK_RST;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                frr_pkg::REG_LIMIT:   r_limit     <= i_cfg_data[12:0];
                frr_pkg::REG_OVERALL: r_ov_to     <= i_cfg_data;
                frr_pkg::REG_IDLE:    r_id_to     <= i_cfg_data[15:0];
                frr_pkg::REG_RESP:    r_resp_code <= i_cfg_data[7:0];
                frr_pkg::REG_NACK:    r_nack_code <= i_cfg_data[7:0];
                default: ;
            endcase
        end
    end

    // Latched item
    frr_pkg::t_action r_action;
    logic [7:0]  r_byte, r_in_seq;
    logic        r_fend;
    logic [11:0] r_addr;

    always_ff @(posedge i_clk) begin
        if (i_cmd.latch) begin
            r_action <= frr_pkg::t_action'(i_action);
            r_byte   <= i_data_byte;
            r_fend   <= i_frame_end;
            r_in_seq <= i_seq;
            r_addr   <= i_read_address;
        end
    end

    // Transaction state
    logic [8:0]  r_cnt;
    logic [31:0] r_hdr;
    logic [7:0]  r_tot_byte, r_idx_byte;
    logic [7:0]  r_act_seq;
    frr_pkg::t_phase r_phase;
    logic        r_tk;
    logic [7:0]  r_total, r_recv;
    logic [12:0] r_lr;
    logic [31:0] r_ov;
    logic [15:0] r_id;
    logic [15:0] r_off;
    logic [7:0]  r_dlen, r_k;
    logic [AW-1:0] r_clr;
    logic        r_ack, r_rd_ok;
    logic [7:0]  r_rd_q, r_fdata;

    logic [7:0]  d_type, d_fseq;
    logic [15:0] d_len;
    logic        d_valid, d_nack, d_frag;
    logic [16:0] c_sum, c_lim;
    logic [31:0] t_ov;
    logic [15:0] t_id;
    logic [7:0]  c_recv;

    // Decode and fragment checks
    always_comb begin
        d_type  = r_hdr[7:0];
        d_fseq  = r_hdr[15:8];
        d_len   = r_hdr[31:16];
        d_valid = (r_cnt >= 9'd4) && (d_len <= 16'(MAX_PAYLOAD))
                  && (17'(d_len) + 17'd4 <= 17'(r_cnt));
        d_nack  = (d_type == r_nack_code) && (d_fseq == r_act_seq);
        d_frag  = d_valid && (r_phase == frr_pkg::PH_RECV) && !d_nack
                  && (d_type == r_resp_code) && (d_fseq == r_act_seq) && (d_len >= 16'd2);
        c_sum   = 17'(r_off) + 17'(r_dlen);
        c_lim   = (17'(r_limit) < DEPTH17) ? 17'(r_limit) : DEPTH17;
        c_recv  = (r_recv == 8'hFF) ? r_recv : r_recv + 8'd1;
        t_ov    = (r_ov == 32'hFFFF_FFFF) ? r_ov : r_ov + 32'd1;
        t_id    = (r_id == 16'hFFFF) ? r_id : r_id + 16'd1;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt     <= '0;
            r_hdr     <= '0;
            r_act_seq <= '0;
            r_phase   <= frr_pkg::PH_IDLE;
            r_tk      <= 1'b0;
            r_total   <= '0;
            r_recv    <= '0;
            r_lr      <= '0;
            r_ov      <= '0;
            r_id      <= '0;
            r_clr     <= '0;
            r_ack     <= 1'b0;
            r_rd_ok   <= 1'b0;
        end else begin
            // clear result flags for a new item
            if (i_cmd.latch) begin
                r_ack   <= 1'b0;
                r_rd_ok <= 1'b0;
            end
            if (i_cmd.clear_step) begin
                r_clr <= r_clr + 1'b1;
            end
            if (i_cmd.exec) begin
                case (r_action)
                    frr_pkg::ACT_START: begin
                        r_act_seq <= r_in_seq;
                        r_phase   <= frr_pkg::PH_RECV;
                        r_tk      <= 1'b0;
                        r_total   <= '0;
                        r_recv    <= '0;
                        r_lr      <= '0;
                        r_ov      <= '0;
                        r_id      <= '0;
                        r_clr     <= '0;
                    end
                    frr_pkg::ACT_BYTE: begin
                        if (r_cnt < FRAME_MAX) begin
                            case (r_cnt)
                                9'd0: r_hdr[7:0]   <= r_byte;
                                9'd1: r_hdr[15:8]  <= r_byte;
                                9'd2: r_hdr[23:16] <= r_byte;
                                9'd3: r_hdr[31:24] <= r_byte;
                                default: ;
                            endcase
                            r_cnt <= r_cnt + 9'd1;
                        end
                    end
                    frr_pkg::ACT_TICK: begin
                        if (r_phase == frr_pkg::PH_RECV) begin
                            r_ov <= t_ov;
                            r_id <= t_id;
                            if (t_ov >= r_ov_to || t_id >= r_id_to) begin
                                r_phase <= frr_pkg::PH_TIMEOUT;
                            end
                        end
                    end
                    frr_pkg::ACT_READ: begin
                        r_rd_ok <= (17'(r_addr) < DEPTH17);
                    end
                    default: ;
                endcase
            end
            // end of frame: validate header and take fragment fields
            if (i_cmd.decode) begin
                r_cnt <= '0;
                if (d_valid) begin
                    r_id <= '0;
                    if (r_phase == frr_pkg::PH_RECV && d_nack) begin
                        r_phase <= frr_pkg::PH_NACK;
                    end
                end
                if (d_frag && !r_tk) begin
                    r_tk    <= 1'b1;
                    r_total <= r_tot_byte;
                end
            end
            // count and acknowledge the fragment
            if (i_cmd.check) begin
                if (c_sum < c_lim && c_sum > 17'(r_lr)) begin
                    r_lr <= c_sum[12:0];
                end
                r_recv <= c_recv;
                if (c_recv >= r_total) begin
                    r_phase <= frr_pkg::PH_DONE;
                end
                r_ack <= 1'b1;
            end
        end
    end

    // Fragment bookkeeping registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.exec && r_action == frr_pkg::ACT_BYTE) begin
            if (r_cnt == 9'd4) r_tot_byte <= r_byte;
            if (r_cnt == 9'd5) r_idx_byte <= r_byte;
        end
        if (i_cmd.decode) begin
            r_off  <= 16'(r_idx_byte) * 16'(FRAG_DATA);
            r_dlen <= d_len[7:0] - 8'd2;
        end
        if (i_cmd.check) begin
            r_k <= '0;
        end else if (i_cmd.copy_wr) begin
            r_k <= r_k + 8'd1;
        end
    end

    // Frame store: write payload bytes, read during copy
    always_ff @(posedge i_clk) begin
        if (i_cmd.exec && r_action == frr_pkg::ACT_BYTE && r_cnt >= 9'd4 && r_cnt < FRAME_MAX) begin
            r_frame_mem[FW'(r_cnt - 9'd4)] <= r_byte;
        end
        if (i_cmd.copy_rd) begin
            r_fdata <= r_frame_mem[FW'(9'(r_k) + 9'd2)];
        end
    end

    // Response store: clear pass, fragment copy, read port
    always_ff @(posedge i_clk) begin
        if (i_cmd.clear_step) begin
            r_resp_mem[r_clr] <= 8'd0;
        end else if (i_cmd.copy_wr) begin
            r_resp_mem[AW'(r_off + 16'(r_k))] <= r_fdata;
        end
        if (i_cmd.exec && r_action == frr_pkg::ACT_READ) begin
            r_rd_q <= r_resp_mem[AW'(r_addr)];
        end
    end

    // Result register
    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            o_send_ack           <= r_ack;
            o_ack_seq            <= r_ack ? r_act_seq : 8'd0;
            o_outcome            <= r_phase;
            o_response_length    <= r_lr;
            o_fragments_received <= r_recv;
            o_fragments_expected <= r_total;
            o_read_byte          <= r_rd_ok ? r_rd_q : 8'd0;
        end
    end

    assign o_status.action     = r_action;
    assign o_status.frame_end  = r_fend;
    assign o_status.frag_go    = d_frag;
    assign o_status.copy_go    = (c_sum < c_lim) && (r_dlen != 8'd0);
    assign o_status.copy_last  = (r_k == r_dlen - 8'd1);
    assign o_status.clear_last = (r_clr == AW'(RESP_DEPTH - 1));

endmodule
`default_nettype wire

>>> test/tb.sv
// Self-checking testbench for the fragmented response reassembler unit.
`default_nettype none
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int FRAG_DATA   = frr_pkg::MAX_PAYLOAD_DEF - 2;
    localparam int FRAME_MAX   = frr_pkg::MAX_PAYLOAD_DEF + 4;
    localparam int STORE_DEPTH = frr_pkg::RESP_DEPTH_DEF;
    localparam int CYCLE_LIMIT = 1500000;
    localparam int ITEM_BUDGET = 550;

    typedef struct packed {
        frr_pkg::t_action act;
        logic [7:0]  octet;
        logic        fend;
        logic [7:0]  sq;
        logic [11:0] addr;
    } t_rx_item;

    typedef struct packed {
        logic        ack;
        logic [7:0]  ack_seq;
        logic [2:0]  outcome;
        logic [12:0] resp_len;
        logic [7:0]  frags_rcv;
        logic [7:0]  frags_total;
        logic [7:0]  rd;
    } t_rx_result;

    typedef logic [7:0] t_octet_q[$];

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_cfg_valid = 1'b0;
    logic [2:0]  i_cfg_index = '0;
    logic [31:0] i_cfg_data = '0;
    logic        i_in_valid = 1'b0;
    logic [1:0]  i_action = '0;
    logic [7:0]  i_data_byte = '0;
    logic        i_frame_end = 1'b0;
    logic [7:0]  i_seq = '0;
    logic [11:0] i_read_address = '0;
    logic        i_out_stall = 1'b0;
    wire         o_cfg_ready;
    wire         o_in_stall;
    wire         o_out_valid;
    wire         o_send_ack;
    wire  [7:0]  o_ack_seq;
    wire  [2:0]  o_outcome;
    wire  [12:0] o_response_length;
    wire  [7:0]  o_fragments_received;
    wire  [7:0]  o_fragments_expected;
    wire  [7:0]  o_read_byte;

    fragmented_response_reassembler_unit dut (.*);

    always #4 i_clk = ~i_clk;

    // Predictor state: configuration copy and reassembly state
    logic [12:0] c_limit   = frr_pkg::LIMIT_RST;
    logic [31:0] c_overall = frr_pkg::OVERALL_RST;
    logic [15:0] c_idle    = frr_pkg::IDLE_RST;
    logic [7:0]  c_resp    = frr_pkg::RESP_RST;
    logic [7:0]  c_nack    = frr_pkg::NACK_RST;

    logic [7:0]  m_frame[FRAME_MAX];
    logic [7:0]  m_resp[STORE_DEPTH];
    int unsigned m_count;
    logic [31:0] m_hdr;
    logic [7:0]  m_seq;
    frr_pkg::t_phase m_phase = frr_pkg::PH_IDLE;
    logic        m_known;
    logic [7:0]  m_total;
    logic [7:0]  m_rcv;
    logic [12:0] m_len;
    logic [31:0] m_overall;
    logic [15:0] m_idle;

    t_rx_item    pending_items[$];
    t_rx_result  expected_results[$];
    bit          calm = 1'b0;
    bit          hold_sender = 1'b0;
    int          n_items = 0;
    int          n_checked = 0;
    int          n_errors = 0;
    int          n_acks = 0;
    int          n_done = 0;
    int          n_nack = 0;
    int          n_tmo = 0;
    int unsigned cycles = 0;

    initial begin
        for (int i = 0; i < STORE_DEPTH; i++) m_resp[i] = '0;
        m_count = 0; m_hdr = '0; m_seq = '0; m_known = 0; m_total = '0;
        m_rcv = '0; m_len = '0; m_overall = '0; m_idle = '0;
    end

    // Advance the reassembly state by one item and return the result it produces
    function automatic t_rx_result predict_reassembly(t_rx_item it);
        t_rx_result  r;
        int unsigned p, n, flen, dlen, off, lim;
        r = '0;
        case (it.act)
            frr_pkg::ACT_START: begin
                m_seq = it.sq;
                for (int i = 0; i < STORE_DEPTH; i++) m_resp[i] = '0;
                m_phase = frr_pkg::PH_RECV; m_known = 0; m_total = '0; m_rcv = '0;
                m_len = '0; m_overall = '0; m_idle = '0;
            end
            frr_pkg::ACT_BYTE: begin
                p = m_count;
                if (p < FRAME_MAX) begin
                    if (p < 4) m_hdr[8*p +: 8] = it.octet;
                    else m_frame[p-4] = it.octet;
                    m_count = p + 1;
                end
                if (it.fend) begin
                    n = m_count;
                    m_count = 0;
                    flen = m_hdr[31:16];
                    if (n >= 4 && flen <= frr_pkg::MAX_PAYLOAD_DEF && 4 + flen <= n) begin
                        m_idle = '0;
                        if (m_phase == frr_pkg::PH_RECV) begin
                            // NACK test takes priority when both codes match
                            if (m_hdr[7:0] == c_nack && m_hdr[15:8] == m_seq) begin
                                m_phase = frr_pkg::PH_NACK;
                            end else if (m_hdr[7:0] == c_resp && m_hdr[15:8] == m_seq
                                         && flen >= 2) begin
                                r.ack = 1'b1;
                                dlen = flen - 2;
                                off = m_frame[1] * FRAG_DATA;
                                lim = (c_limit < STORE_DEPTH) ? c_limit : STORE_DEPTH;
                                if (!m_known) begin
                                    m_known = 1'b1;
                                    m_total = m_frame[0];
                                end
                                // drop the data of a copy that would reach the limit
                                if (off + dlen < lim) begin
                                    for (int i = 0; i < dlen; i++) m_resp[off+i] = m_frame[2+i];
                                    if (off + dlen > m_len) m_len = 13'(off + dlen);
                                end
                                if (m_rcv < 8'hFF) m_rcv++;
                                if (m_rcv >= m_total) m_phase = frr_pkg::PH_DONE;
                            end
                        end
                    end
                end
            end
            frr_pkg::ACT_TICK: begin
                if (m_phase == frr_pkg::PH_RECV) begin
                    if (m_overall != 32'hFFFF_FFFF) m_overall++;
                    if (m_idle != 16'hFFFF) m_idle++;
                    if (m_overall >= c_overall || m_idle >= c_idle)
                        m_phase = frr_pkg::PH_TIMEOUT;
                end
            end
            default: r.rd = m_resp[it.addr];
        endcase
        r.ack_seq     = r.ack ? m_seq : '0;
        r.outcome     = m_phase;
        r.resp_len    = m_len;
        r.frags_rcv   = m_rcv;
        r.frags_total = m_total;
        return r;
    endfunction

    task automatic report_mismatch(string what, int got, int want);
        $display("mismatch %s at result %0d: got %0d, want %0d", what, n_checked, got, want);
        n_errors++;
    endtask

    // Drive input transfers; predict each accepted one
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
        end else begin
            if (i_in_valid && !o_in_stall) begin
                expected_results.push_back(predict_reassembly(pending_items.pop_front()));
            end
            if (!(i_in_valid && o_in_stall)) begin
                if (pending_items.size() > 0 && !hold_sender &&
                    (calm || $urandom_range(99) >= 30)) begin
                    i_in_valid     <= 1'b1;
                    i_action       <= pending_items[0].act;
                    i_data_byte    <= pending_items[0].octet;
                    i_frame_end    <= pending_items[0].fend;
                    i_seq          <= pending_items[0].sq;
                    i_read_address <= pending_items[0].addr;
                end else begin
                    i_in_valid <= 1'b0;
                end
            end
        end
    end

    // Check output transfers against the oldest expectation
    always @(posedge i_clk) begin
        t_rx_result w;
        if (i_rst_n) begin
            if (o_out_valid && !i_out_stall) begin
                if (expected_results.size() == 0) begin
                    $display("unexpected result transfer at cycle %0d", cycles);
                    n_errors++;
                end else begin
                    w = expected_results.pop_front();
                    if (o_send_ack !== w.ack) report_mismatch("send_ack", o_send_ack, w.ack);
                    if (o_ack_seq !== w.ack_seq) report_mismatch("ack_seq", o_ack_seq, w.ack_seq);
                    if (o_outcome !== w.outcome) report_mismatch("outcome", o_outcome, w.outcome);
                    if (o_response_length !== w.resp_len)
                        report_mismatch("response_length", o_response_length, w.resp_len);
                    if (o_fragments_received !== w.frags_rcv)
                        report_mismatch("fragments_received", o_fragments_received, w.frags_rcv);
                    if (o_fragments_expected !== w.frags_total)
                        report_mismatch("fragments_expected", o_fragments_expected,
                                        w.frags_total);
                    if (o_read_byte !== w.rd) report_mismatch("read_byte", o_read_byte, w.rd);
                    if (w.ack) n_acks++;
                    if (w.outcome == frr_pkg::PH_DONE) n_done++;
                    if (w.outcome == frr_pkg::PH_NACK) n_nack++;
                    if (w.outcome == frr_pkg::PH_TIMEOUT) n_tmo++;
                    n_checked++;
                end
            end
            i_out_stall <= !calm && ($urandom_range(99) < 30);
        end
    end

    // Bound the run
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles", cycles);
            $display("FAIL fragmented_response_reassembler_unit");
            $finish;
        end
    end

    task automatic push_item(frr_pkg::t_action act, logic [7:0] octet, logic fend,
                             logic [7:0] sq, logic [11:0] addr);
        t_rx_item it;
        it.act = act; it.octet = octet; it.fend = fend; it.sq = sq; it.addr = addr;
        pending_items.push_back(it);
        n_items++;
    endtask

    task automatic push_start(logic [7:0] sq);
        push_item(frr_pkg::ACT_START, $urandom, $urandom, sq, $urandom);
    endtask

    task automatic push_ticks(int count);
        for (int i = 0; i < count; i++)
            push_item(frr_pkg::ACT_TICK, $urandom, $urandom, $urandom, $urandom);
    endtask

    task automatic push_read(logic [11:0] addr);
        push_item(frr_pkg::ACT_READ, $urandom, $urandom, $urandom, addr);
    endtask

    task automatic push_octets(t_octet_q q);
        foreach (q[i]) push_item(frr_pkg::ACT_BYTE, q[i], i == q.size() - 1, $urandom, $urandom);
    endtask

    // Build a frame; cut removes trailing bytes, extra appends discarded bytes
    task automatic push_frame(logic [7:0] ftype, logic [7:0] fseq, logic [15:0] flen,
                              logic [7:0] total, logic [7:0] idx, int dlen, int cut,
                              int extra);
        t_octet_q q;
        q = {ftype, fseq, flen[7:0], flen[15:8], total, idx};
        for (int i = 0; i < dlen + extra; i++) q.push_back($urandom);
        for (int i = 0; i < cut && q.size() > 1; i++) void'(q.pop_back());
        push_octets(q);
    endtask

    task automatic push_fragment(logic [7:0] fseq, logic [7:0] total, logic [7:0] idx,
                                 int dlen);
        push_frame(c_resp, fseq, 16'(dlen + 2), total, idx, dlen, 0, 0);
    endtask

    // Noise: random actions and broken frames
    task automatic push_noise(logic [7:0] sq);
        case ($urandom_range(5))
            0: push_item(frr_pkg::ACT_BYTE, $urandom, $urandom, $urandom, $urandom);
            1: push_frame($urandom, $urandom, $urandom, $urandom, $urandom,
                          $urandom_range(4), $urandom_range(3), 0);
            2: push_frame(c_resp, sq, $urandom_range(4, 12), $urandom, $urandom, 2, 3, 0);
            3: push_frame(c_resp, sq, 16'h0100 | $urandom_range(255), 1, 0, 2, 0, 0);
            4: push_read($urandom);
            default: push_frame(c_resp, sq, 1, 0, 0, 0, 0, 0);
        endcase
    endtask

    // One well-formed exchange with random content and occasional disturbances
    task automatic push_exchange(int dmax);
        logic [7:0] s, total, idx;
        int         nfrag;
        s = $urandom;
        nfrag = $urandom_range(1, 5);
        total = ($urandom_range(19) == 0) ? $urandom : nfrag;
        push_start(s);
        for (int k = 0; k < nfrag; k++) begin
            idx = ($urandom_range(19) == 0) ? $urandom : k;
            if ($urandom_range(9) == 0) push_noise(s);
            if ($urandom_range(4) == 0) push_ticks($urandom_range(1, 4));
            if ($urandom_range(29) == 0) begin
                push_frame(c_nack, s, $urandom_range(4), 0, 0, 0, 0, 0);
            end else if ($urandom_range(14) == 0) begin
                push_fragment(s + 1, total, idx, $urandom_range(dmax));
            end
            push_fragment(s, total, idx, $urandom_range(dmax));
            if ($urandom_range(9) == 0) push_fragment(s, total, idx, $urandom_range(dmax));
        end
        for (int i = $urandom_range(1, 4); i > 0; i--)
            push_read(($urandom_range(3) == 0) ? $urandom : $urandom_range(0, 1300));
        if ($urandom_range(3) == 0) push_ticks($urandom_range(1, 20));
    endtask

    task automatic wait_drained();
        while (pending_items.size() > 0 || i_in_valid || expected_results.size() > 0)
            @(posedge i_clk);
        repeat (20) @(posedge i_clk);
    endtask

    task automatic write_register(frr_pkg::t_reg_index idx, logic [31:0] value);
        @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= value;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        case (idx)
            frr_pkg::REG_LIMIT:   c_limit = value[12:0];
            frr_pkg::REG_OVERALL: c_overall = value;
            frr_pkg::REG_IDLE:    c_idle = value[15:0];
            frr_pkg::REG_RESP:    c_resp = value[7:0];
            default:              c_nack = value[7:0];
        endcase
    endtask

    task automatic apply_setting(logic [12:0] lim, logic [31:0] ovr, logic [15:0] idl,
                                 logic [7:0] rsp, logic [7:0] nck);
        wait_drained();
        write_register(frr_pkg::REG_LIMIT, lim);
        write_register(frr_pkg::REG_OVERALL, ovr);
        write_register(frr_pkg::REG_IDLE, idl);
        write_register(frr_pkg::REG_RESP, rsp);
        write_register(frr_pkg::REG_NACK, nck);
    endtask

    task automatic run_random(int budget, int dmax);
        int stop;
        stop = n_items + budget;
        while (n_items < stop) begin
            if ($urandom_range(7) == 0) push_noise($urandom);
            else push_exchange(dmax);
            // let the driver work through the queue as it fills
            while (pending_items.size() > 40) @(posedge i_clk);
        end
    endtask

    initial begin
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed: idle behavior, broken frames, total of zero, NACK, late frames
        push_read(12'hFFF);
        push_ticks(1);
        push_frame(c_resp, 0, 2, 1, 0, 0, 0, 0);
        push_start(8'hFF);
        push_octets('{8'h04, 8'hFF, 8'h00});
        push_frame(c_resp, 8'hFF, 16'hFFFF, 1, 0, 0, 0, 0);
        push_frame(c_resp, 8'hFF, 6, 1, 0, 4, 2, 0);
        push_frame(c_nack, 8'h00, 0, 0, 0, 0, 0, 0);
        push_frame(c_resp, 8'hFF, 3, 0, 0, 1, 0, 0);
        push_frame(c_nack, 8'hFF, 0, 0, 0, 0, 0, 0);
        push_read(12'h000);
        push_start(8'h00);
        push_frame(c_nack, 8'h00, 0, 0, 0, 0, 0, 0);
        push_ticks(1);
        run_random(50, 12);

        // Sender hold-off with results outstanding
        hold_sender = 1'b1;
        while (expected_results.size() > 0 || i_in_valid) @(posedge i_clk);
        hold_sender = 1'b0;

        // Minimum limit and timeouts, extreme type codes
        apply_setting(13'd1, 32'd1, 16'd1, 8'h00, 8'hFF);
        run_random(25, 6);

        // Maximum limit and timeouts, no idling; full and overlong frames
        apply_setting(13'd4096, 32'hFFFF_FFFF, 16'hFFFF, 8'hFF, 8'h00);
        calm = 1'b1;
        push_start(8'h5A);
        push_frame(8'hFF, 8'h5A, 255, 3, 15, 253, 0, 3);
        push_fragment(8'h5A, 3, 16, 5);
        push_read(12'd3795);
        push_read(12'd4047);
        run_random(25, 10);
        wait_drained();
        calm = 1'b0;

        // Equal type codes, short overall timeout
        apply_setting(13'd600, 32'd40, 16'hFFFF, 8'h07, 8'h07);
        run_random(25, 10);

        // Short idle timeout
        apply_setting(13'd2000, 32'd200, 16'd6, frr_pkg::RESP_RST, frr_pkg::NACK_RST);
        run_random(30, 12);

        wait_drained();
        repeat (600) @(posedge i_clk);
        if (expected_results.size() > 0) begin
            $display("%0d expected results never arrived", expected_results.size());
            n_errors++;
        end
        $display("covered %0d items, %0d results checked, %0d acks", n_items, n_checked,
                 n_acks);
        $display("outcomes seen: %0d complete, %0d nack, %0d timeout", n_done, n_nack, n_tmo);
        if (n_errors == 0) begin
            $display("PASS fragmented_response_reassembler_unit");
        end else begin
            $display("FAIL fragmented_response_reassembler_unit");
        end
        $finish;
    end
endmodule
`default_nettype wire
